// ===== rtl/cifp_pkg.sv =====
// ----------------------------------------------------------------------------
// cifp_pkg: shared types and codes of the token structure parser
// token kinds, event codes, parser mode and the event record
// ----------------------------------------------------------------------------
package cifp_pkg;

  localparam int MAX_TAGS_DEFAULT = 64;

  localparam int KIND_W  = 4;
  localparam int REF_W   = 16;
  localparam int CODE_W  = 3;
  localparam int COL_W   = 6;
  localparam int COUNT_W = 7;
  localparam int EV_MAX  = 3;

  // token kinds
  localparam logic [KIND_W-1:0] TK_ERROR   = 4'd0;
  localparam logic [KIND_W-1:0] TK_DATA    = 4'd1;
  localparam logic [KIND_W-1:0] TK_EOF     = 4'd2;
  localparam logic [KIND_W-1:0] TK_TAG     = 4'd3;
  localparam logic [KIND_W-1:0] TK_LOOP    = 4'd4;
  localparam logic [KIND_W-1:0] TK_VAL_LO  = 4'd5;
  localparam logic [KIND_W-1:0] TK_VAL_HI  = 4'd12;

  // event codes
  localparam logic [CODE_W-1:0] EV_BEGIN_DATA = 3'd0;
  localparam logic [CODE_W-1:0] EV_END_DATA   = 3'd1;
  localparam logic [CODE_W-1:0] EV_ITEM       = 3'd2;
  localparam logic [CODE_W-1:0] EV_BEGIN_LOOP = 3'd3;
  localparam logic [CODE_W-1:0] EV_LOOP_VALUE = 3'd4;
  localparam logic [CODE_W-1:0] EV_ROW_END    = 3'd5;
  localparam logic [CODE_W-1:0] EV_END_LOOP   = 3'd6;
  localparam logic [CODE_W-1:0] EV_UNEXPECTED = 3'd7;

  typedef enum logic [2:0] {
    MODE_NONE = 3'b001,
    MODE_ITEM = 3'b010,
    MODE_LOOP = 3'b100
  } mode_t;

  typedef struct packed {
    logic              in_data_block;
    mode_t             data_mode;
    logic              loop_values_phase;
    logic [COL_W-1:0]  column_index;
  } ctrl_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COL_W-1:0]   column;
    logic [COUNT_W-1:0] column_count;
  } event_t;

  function automatic logic is_value(input logic [KIND_W-1:0] kind);
    return (kind >= TK_VAL_LO) && (kind <= TK_VAL_HI);
  endfunction

endpackage

// ===== rtl/cif_token_structure_parser.sv =====
// ----------------------------------------------------------------------------
// cif_token_structure_parser: block, item and loop structure of a token stream
// path: a token passes the input register, then the result register, before its first event
// throughput: one token per cycle while m_tready is high and no token gives more than one event;
//   a token with several events holds the input while they drain from the three-entry result register
// reset: synchronous, clears the parser to top level with empty tag count
// ----------------------------------------------------------------------------
module cif_token_structure_parser #(
  parameter int MAX_TAGS = cifp_pkg::MAX_TAGS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // token input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] token_ref
  input  logic [3:0]  s_tuser,   // [3:0] token_kind
  // event output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [5:0] column, [12:6] column_count,
                                 // [28:13] value_ref, [44:29] key_ref, [47:45] zero
  output logic [2:0]  m_tuser,   // [2:0] event_code
  output logic        m_tlast    // last event of the token
);

  localparam int TC_W = $clog2(MAX_TAGS + 1);

  // input register
  logic                                in_valid;
  logic [cifp_pkg::KIND_W-1:0]         in_kind;
  logic [cifp_pkg::REF_W-1:0]          in_ref;

  // parser state
  cifp_pkg::ctrl_t                     ctrl;
  cifp_pkg::ctrl_t                     ctrl_next;
  logic [TC_W-1:0]                     tag_count;
  logic [TC_W-1:0]                     tag_count_next;
  logic [cifp_pkg::REF_W-1:0]          item_key_ref;
  logic [cifp_pkg::REF_W-1:0]          item_key_ref_next;

  // events of the token in the input register
  cifp_pkg::event_t [cifp_pkg::EV_MAX-1:0] step_events;
  logic [1:0]                          step_count;
  logic [cifp_pkg::REF_W-1:0]          step_key;

  // result register: events queue up in slot 0 first
  cifp_pkg::event_t [cifp_pkg::EV_MAX-1:0] out_events;
  logic [1:0]                          out_remaining;
  logic [cifp_pkg::REF_W-1:0]          out_value_ref;
  logic [cifp_pkg::REF_W-1:0]          out_key_ref;

  logic                                out_free;
  logic                                take;

  // result register can take a new list when empty or on its final transaction
  assign out_free = (out_remaining == 2'd0) || (out_remaining == 2'd1 && m_tready);
  assign take     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  cifp_step #(
    .MAX_TAGS (MAX_TAGS),
    .TC_W     (TC_W)
  ) u_step (
    .ctrl           (ctrl),
    .tag_count      (tag_count),
    .key_ref        (item_key_ref),
    .kind           (in_kind),
    .token_ref      (in_ref),
    .ctrl_next      (ctrl_next),
    .tag_count_next (tag_count_next),
    .key_ref_next   (item_key_ref_next),
    .events         (step_events),
    .event_count    (step_count),
    .event_key      (step_key)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      ctrl          <= '{in_data_block: 1'b0, data_mode: cifp_pkg::MODE_NONE,
                         loop_values_phase: 1'b0, column_index: '0};
      tag_count     <= '0;
      item_key_ref  <= '0;
      out_remaining <= 2'd0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (take) begin
        ctrl          <= ctrl_next;
        tag_count     <= tag_count_next;
        item_key_ref  <= item_key_ref_next;
        out_remaining <= step_count;
      end else if (out_remaining != 2'd0 && m_tready) begin
        out_remaining <= out_remaining - 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_ref  <= s_tdata;
    end
    if (take) begin
      out_events    <= step_events;
      out_value_ref <= in_ref;
      out_key_ref   <= step_key;
    end else if (out_remaining != 2'd0 && m_tready) begin
      // next event of the same token moves to the head
      out_events[0] <= out_events[1];
      out_events[1] <= out_events[2];
    end
  end

  assign m_tvalid = (out_remaining != 2'd0);
  assign m_tlast  = (out_remaining == 2'd1);
  assign m_tuser  = out_events[0].code;
  assign m_tdata  = {3'b000, out_key_ref, out_value_ref,
                     out_events[0].column_count, out_events[0].column};

endmodule

// ===== rtl/cifp_step.sv =====
// ----------------------------------------------------------------------------
// cifp_step: next-state and event list for one token
// closes nested constructs and re-dispatches the token at the outer level
// ----------------------------------------------------------------------------
module cifp_step #(
  parameter int MAX_TAGS = cifp_pkg::MAX_TAGS_DEFAULT,
  parameter int TC_W     = $clog2(MAX_TAGS + 1)
) (
  input  cifp_pkg::ctrl_t                           ctrl,
  input  logic [TC_W-1:0]                           tag_count,
  input  logic [cifp_pkg::REF_W-1:0]                key_ref,
  input  logic [cifp_pkg::KIND_W-1:0]               kind,
  input  logic [cifp_pkg::REF_W-1:0]                token_ref,
  output cifp_pkg::ctrl_t                           ctrl_next,
  output logic [TC_W-1:0]                           tag_count_next,
  output logic [cifp_pkg::REF_W-1:0]                key_ref_next,
  output cifp_pkg::event_t [cifp_pkg::EV_MAX-1:0]   events,
  output logic [1:0]                                event_count,
  output logic [cifp_pkg::REF_W-1:0]                event_key
);

  localparam int CMP_W = (TC_W > cifp_pkg::COUNT_W) ? TC_W : cifp_pkg::COUNT_W;

  logic [cifp_pkg::COUNT_W-1:0] col_plus;
  logic [CMP_W-1:0]             count_ext;
  logic                         row_done;
  logic                         redispatch;
  logic [1:0]                   slot;

  assign col_plus  = {1'b0, ctrl.column_index} + cifp_pkg::COUNT_W'(1);
  assign count_ext = CMP_W'(tag_count);
  assign row_done  = (CMP_W'(col_plus) == count_ext);

  always_comb begin
    ctrl_next      = ctrl;
    tag_count_next = tag_count;
    key_ref_next   = key_ref;
    events         = '0;
    event_count    = 2'd0;
    event_key      = '0;
    redispatch     = 1'b0;
    slot           = 2'd0;

    if (!ctrl.in_data_block) begin
      // top level
      if (kind == cifp_pkg::TK_DATA) begin
        ctrl_next.in_data_block = 1'b1;
        events[0].code = cifp_pkg::EV_BEGIN_DATA;
      end else if (kind == cifp_pkg::TK_EOF) begin
        events[0].code = cifp_pkg::EV_END_DATA;
      end else begin
        events[0].code = cifp_pkg::EV_UNEXPECTED;
      end
      event_count = 2'd1;
    end else begin
      unique case (ctrl.data_mode)
        cifp_pkg::MODE_ITEM: begin
          event_count = 2'd1;
          if (cifp_pkg::is_value(kind)) begin
            events[0].code              = cifp_pkg::EV_ITEM;
            event_key                   = key_ref;
            ctrl_next.data_mode         = cifp_pkg::MODE_NONE;
            ctrl_next.loop_values_phase = 1'b0;
          end else begin
            events[0].code = cifp_pkg::EV_UNEXPECTED;
          end
        end
        cifp_pkg::MODE_LOOP: begin
          if (kind == cifp_pkg::TK_EOF) begin
            // loop closes silently, counts are kept
            ctrl_next.data_mode         = cifp_pkg::MODE_NONE;
            ctrl_next.loop_values_phase = 1'b0;
            redispatch                  = 1'b1;
          end else if (!ctrl.loop_values_phase && kind == cifp_pkg::TK_TAG) begin
            if (tag_count != TC_W'(MAX_TAGS)) begin
              tag_count_next = tag_count + TC_W'(1);
            end
          end else begin
            if (!ctrl.loop_values_phase) begin
              events[0].code              = cifp_pkg::EV_BEGIN_LOOP;
              events[0].column_count      = count_ext[cifp_pkg::COUNT_W-1:0];
              ctrl_next.loop_values_phase = 1'b1;
              slot                        = 2'd1;
            end
            if (cifp_pkg::is_value(kind)) begin
              events[slot].code   = cifp_pkg::EV_LOOP_VALUE;
              events[slot].column = ctrl.column_index;
              if (row_done) begin
                events[slot + 2'd1].code = cifp_pkg::EV_ROW_END;
                ctrl_next.column_index   = '0;
                event_count              = slot + 2'd2;
              end else begin
                ctrl_next.column_index = col_plus[cifp_pkg::COL_W-1:0];
                event_count            = slot + 2'd1;
              end
            end else begin
              events[slot].code           = cifp_pkg::EV_END_LOOP;
              ctrl_next.column_index      = '0;
              tag_count_next              = '0;
              ctrl_next.data_mode         = cifp_pkg::MODE_NONE;
              ctrl_next.loop_values_phase = 1'b0;
              event_count                 = slot + 2'd1;
              redispatch                  = 1'b1;
            end
          end
        end
        default: begin
          redispatch = 1'b1;
        end
      endcase

      // token handled at data block level, after any loop was closed
      if (redispatch) begin
        case (kind)
          cifp_pkg::TK_DATA: begin
            events[event_count].code = cifp_pkg::EV_BEGIN_DATA;
            event_count              = event_count + 2'd1;
          end
          cifp_pkg::TK_EOF: begin
            ctrl_next.in_data_block = 1'b0;
          end
          cifp_pkg::TK_TAG: begin
            ctrl_next.data_mode = cifp_pkg::MODE_ITEM;
            key_ref_next        = token_ref;
          end
          cifp_pkg::TK_LOOP: begin
            ctrl_next.data_mode = cifp_pkg::MODE_LOOP;
          end
          default: begin
            events[event_count].code = cifp_pkg::EV_UNEXPECTED;
            event_count              = event_count + 2'd1;
          end
        endcase
      end
    end
  end

endmodule

// ===== test/cifp_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cifp_event_checker: scoreboard for the token structure parser
// watches both stream channels, predicts events per token and compares
// ----------------------------------------------------------------------------
module cifp_event_checker #(
  parameter int MAX_TAGS = cifp_pkg::MAX_TAGS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          events_seen,
  output logic [7:0]  codes_seen
);

  typedef enum logic [1:0] {OPEN_NONE, OPEN_ITEM, OPEN_LOOP} open_t;
  typedef enum logic [1:0] {FLOW_CARRY, FLOW_COMPLETE, FLOW_BACK, FLOW_ERR} flow_t;

  typedef struct packed {
    logic [cifp_pkg::CODE_W-1:0]  code;
    logic [cifp_pkg::COL_W-1:0]   column;
    logic [cifp_pkg::COUNT_W-1:0] count;
    logic [cifp_pkg::REF_W-1:0]   vref;
    logic [cifp_pkg::REF_W-1:0]   kref;
    logic                         last;
  } parse_event_t;

  // parser state as predicted
  bit                          in_block;
  open_t                       open;
  bit                          values_phase;
  int                          tag_count;
  int                          col;
  logic [cifp_pkg::REF_W-1:0]  key;

  parse_event_t      burst [3];
  int                burst_n;
  parse_event_t      event_q [$];

  initial begin
    errors      = 0;
    events_seen = 0;
    codes_seen  = '0;
    pending     = 0;
  end

  function automatic bit carries_value(input logic [cifp_pkg::KIND_W-1:0] kind);
    return kind >= cifp_pkg::TK_VAL_LO && kind <= cifp_pkg::TK_VAL_HI;
  endfunction

  function automatic void emit(input logic [cifp_pkg::CODE_W-1:0] code,
                               input int column, input int count,
                               input logic [cifp_pkg::REF_W-1:0] vref,
                               input logic [cifp_pkg::REF_W-1:0] kref);
    parse_event_t ev;
    ev.code   = code;
    ev.column = column[cifp_pkg::COL_W-1:0];
    ev.count  = count[cifp_pkg::COUNT_W-1:0];
    ev.vref   = vref;
    ev.kref   = kref;
    ev.last   = 1'b0;
    if (burst_n < 3) begin
      burst[burst_n] = ev;
      burst_n++;
    end
  endfunction

  // one token inside an open loop
  function automatic flow_t loop_token(input logic [cifp_pkg::KIND_W-1:0] kind,
                                       input logic [cifp_pkg::REF_W-1:0] tref);
    int nxt;
    if (kind == cifp_pkg::TK_EOF) return FLOW_BACK;
    if (!values_phase) begin
      if (kind == cifp_pkg::TK_TAG) begin
        if (tag_count < MAX_TAGS) tag_count++;
        return FLOW_CARRY;
      end
      values_phase = 1'b1;
      emit(cifp_pkg::EV_BEGIN_LOOP, 0, tag_count, tref, '0);
    end
    if (carries_value(kind)) begin
      nxt = col + 1;
      emit(cifp_pkg::EV_LOOP_VALUE, col, 0, tref, '0);
      if (nxt == tag_count) begin
        emit(cifp_pkg::EV_ROW_END, 0, 0, tref, '0);
        col = 0;
      end else begin
        col = nxt & 63;
      end
      return FLOW_CARRY;
    end
    emit(cifp_pkg::EV_END_LOOP, 0, 0, tref, '0);
    col       = 0;
    tag_count = 0;
    return FLOW_BACK;
  endfunction

  task automatic predict_token(input logic [cifp_pkg::KIND_W-1:0] kind,
                               input logic [cifp_pkg::REF_W-1:0] tref);
    flow_t        flow;
    bit           handled;
    parse_event_t ev;
    burst_n = 0;
    flow    = FLOW_BACK;
    if (in_block) begin
      handled = 1'b0;
      if (open == OPEN_ITEM) begin
        handled = 1'b1;
        if (!carries_value(kind)) begin
          flow = FLOW_ERR;
        end else begin
          emit(cifp_pkg::EV_ITEM, 0, 0, tref, key);
          open         = OPEN_NONE;
          values_phase = 1'b0;
          flow         = FLOW_CARRY;
        end
      end else if (open == OPEN_LOOP) begin
        if (loop_token(kind, tref) == FLOW_CARRY) begin
          handled = 1'b1;
          flow    = FLOW_CARRY;
        end else begin
          open         = OPEN_NONE;
          values_phase = 1'b0;
        end
      end
      if (!handled) begin
        case (kind)
          cifp_pkg::TK_DATA: flow = FLOW_BACK;
          cifp_pkg::TK_EOF:  flow = FLOW_COMPLETE;
          cifp_pkg::TK_TAG: begin
            open = OPEN_ITEM;
            key  = tref;
            flow = FLOW_CARRY;
          end
          cifp_pkg::TK_LOOP: begin
            open = OPEN_LOOP;
            flow = FLOW_CARRY;
          end
          default: flow = FLOW_ERR;
        endcase
      end
    end
    case (flow)
      FLOW_ERR:      emit(cifp_pkg::EV_UNEXPECTED, 0, 0, tref, '0);
      FLOW_COMPLETE: in_block = 1'b0;
      FLOW_BACK: begin
        if (kind == cifp_pkg::TK_DATA) begin
          in_block = 1'b1;
          emit(cifp_pkg::EV_BEGIN_DATA, 0, 0, tref, '0);
        end else if (kind == cifp_pkg::TK_EOF) begin
          in_block = 1'b0;
          emit(cifp_pkg::EV_END_DATA, 0, 0, tref, '0);
        end else begin
          emit(cifp_pkg::EV_UNEXPECTED, 0, 0, tref, '0);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < burst_n; i++) begin
      ev      = burst[i];
      ev.last = (i == burst_n - 1);
      event_q.push_back(ev);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t: event %0d %s: expected %0h, got %0h", $time, events_seen, what, want, got);
    errors++;
  endtask

  task automatic check_event();
    parse_event_t want;
    events_seen++;
    codes_seen[m_tuser] = 1'b1;
    if (event_q.size() == 0) begin
      report_mismatch("arrived with nothing expected, code", '0, m_tuser);
      return;
    end
    want = event_q.pop_front();
    if (m_tuser != want.code)          report_mismatch("event_code", want.code, m_tuser);
    if (m_tdata[5:0] != want.column)   report_mismatch("column", want.column, m_tdata[5:0]);
    if (m_tdata[12:6] != want.count)   report_mismatch("column_count", want.count, m_tdata[12:6]);
    if (m_tdata[28:13] != want.vref)   report_mismatch("value_ref", want.vref, m_tdata[28:13]);
    if (m_tdata[44:29] != want.kref)   report_mismatch("key_ref", want.kref, m_tdata[44:29]);
    if (m_tdata[47:45] != '0)          report_mismatch("pad bits", '0, m_tdata[47:45]);
    if (m_tlast != want.last)          report_mismatch("last", want.last, m_tlast);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_block     = 1'b0;
      open         = OPEN_NONE;
      values_phase = 1'b0;
      tag_count    = 0;
      col          = 0;
      key          = '0;
      event_q.delete();
    end else begin
      if (s_tvalid && s_tready) predict_token(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_event();
    end
    pending <= event_q.size();
  end

endmodule

// ===== test/cif_token_structure_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_token_structure_parser_tb: token stream test of the structure parser
// directed tokens for every structure case, wide and tagless loops, then
// random well-formed blocks with noise; random idling on both channels
// ----------------------------------------------------------------------------
module cif_token_structure_parser_tb;

  // kinds outside the named set all count as other
  localparam logic [cifp_pkg::KIND_W-1:0] TK_OTHER     = 4'd13;
  localparam logic [cifp_pkg::KIND_W-1:0] TK_OTHER_MAX = 4'd15;

  localparam int RANDOM_ITEMS   = 55;
  localparam int CALM_ITEMS     = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [15:0] token_ref
  logic [3:0]  s_tuser  = '0;   // [3:0] token_kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // [5:0] column, [12:6] column_count,
                                // [28:13] value_ref, [44:29] key_ref
  logic [2:0]  m_tuser;         // [2:0] event_code
  logic        m_tlast;

  int          errors;
  int          pending;
  int          events_seen;
  logic [7:0]  codes_seen;

  bit          idle_on = 1'b1;   // random idling on both channels
  int          stall_left = 0;
  int          sent_n = 0;
  int          quiet_cycles = 0;
  bit          in_block_hint = 1'b0;  // rough guess of the parser's block state

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cif_token_structure_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  cifp_event_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .pending     (pending),
    .events_seen (events_seen),
    .codes_seen  (codes_seen)
  );

  // event side: random stall bursts while idling is on
  always @(posedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 5);
      m_tready   <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      m_tready   <= 1'b1;
    end
  end

  // watchdog: cycles in a row with no transaction on either channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d events pending",
               WATCHDOG_LIMIT, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] random_ref();
    return 16'($urandom);
  endfunction

  function automatic logic [3:0] value_kind();
    return 4'($urandom_range(cifp_pkg::TK_VAL_LO, cifp_pkg::TK_VAL_HI));
  endfunction

  // a kind that never closes an item: anything but a value
  function automatic logic [3:0] non_value_kind();
    logic [3:0] k;
    k = 4'($urandom_range(0, 15));
    if (k >= cifp_pkg::TK_VAL_LO && k <= cifp_pkg::TK_VAL_HI) k = TK_OTHER;
    return k;
  endfunction

  // one token transaction; valid stays high across back-to-back tokens
  task automatic send_token(input logic [3:0] kind, input logic [15:0] tref);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tref;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    sent_n++;
    if (kind == cifp_pkg::TK_DATA) in_block_hint = 1'b1;
    if (kind == cifp_pkg::TK_EOF)  in_block_hint = 1'b0;
  endtask

  // stop sending until every predicted event has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic item_chunk();
    if (!in_block_hint) send_token(cifp_pkg::TK_DATA, random_ref());
    send_token(cifp_pkg::TK_TAG, random_ref());
    if ($urandom_range(0, 9) != 0) begin
      send_token(value_kind(), random_ref());
    end else begin
      send_token(non_value_kind(), random_ref());
    end
  endtask

  task automatic loop_chunk(input int ntags, input int nvals);
    if (!in_block_hint) send_token(cifp_pkg::TK_DATA, random_ref());
    send_token(cifp_pkg::TK_LOOP, random_ref());
    repeat (ntags) send_token(cifp_pkg::TK_TAG, random_ref());
    repeat (nvals) send_token(value_kind(), random_ref());
  endtask

  // mostly well-formed blocks, items and loops with some noise mixed in
  task automatic random_chunk();
    int pick;
    int ntags;
    pick  = $urandom_range(0, 99);
    ntags = $urandom_range(0, 4);
    if (pick < 8) begin
      send_token(4'($urandom_range(0, 15)), random_ref());
    end else if (pick < 18) begin
      send_token(cifp_pkg::TK_DATA, random_ref());
    end else if (pick < 45) begin
      item_chunk();
    end else if (pick < 85) begin
      // whole rows, sometimes a partial row left open
      loop_chunk(ntags, ntags * $urandom_range(0, 3) + $urandom_range(0, 1) *
                 $urandom_range(0, ntags == 0 ? 3 : ntags - 1));
    end else if (pick < 93) begin
      send_token(cifp_pkg::TK_EOF, random_ref());
    end else begin
      // broken loop: a stray token in the middle of the header or a row
      loop_chunk(ntags, $urandom_range(0, 2));
      send_token(non_value_kind(), random_ref());
    end
  endtask

  initial begin
    int stop_at;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: top-level errors, items, loops, nested closes
    send_token(cifp_pkg::TK_TAG, 16'hFFFF);    // tag at top level is unexpected
    send_token(cifp_pkg::TK_ERROR, 16'h0000);  // lexer error
    send_token(TK_OTHER_MAX, 16'h5A5A);        // other kind, high bit set
    send_token(cifp_pkg::TK_EOF, 16'hFFFF);    // eof at top level gives end_data
    send_token(cifp_pkg::TK_DATA, 16'h0000);
    send_token(cifp_pkg::TK_TAG, 16'hFFFF);
    send_token(cifp_pkg::TK_VAL_LO, 16'h1234); // item value carries the stored tag
    send_token(cifp_pkg::TK_TAG, 16'h0000);
    send_token(cifp_pkg::TK_LOOP, 16'hA5A5);   // non-value after tag, item stays open
    send_token(cifp_pkg::TK_VAL_HI, 16'hFFFF);
    send_token(cifp_pkg::TK_LOOP, random_ref());
    send_token(cifp_pkg::TK_TAG, random_ref());
    send_token(cifp_pkg::TK_TAG, random_ref());
    send_token(value_kind(), random_ref());  // begin_loop then first column
    send_token(value_kind(), random_ref());  // last column, row end
    send_token(value_kind(), random_ref());
    send_token(cifp_pkg::TK_DATA, random_ref());  // closes the loop, new block
    send_token(cifp_pkg::TK_LOOP, random_ref());
    send_token(cifp_pkg::TK_TAG, random_ref());
    send_token(cifp_pkg::TK_DATA, random_ref());  // three events from one token
    send_token(cifp_pkg::TK_LOOP, random_ref());
    send_token(value_kind(), random_ref());  // loop with no tags
    send_token(TK_OTHER, random_ref());      // closes the loop, then unexpected
    send_token(cifp_pkg::TK_EOF, random_ref());   // eof in a block with nothing open
    send_token(cifp_pkg::TK_DATA, random_ref());
    loop_chunk(1, 0);
    send_token(cifp_pkg::TK_EOF, random_ref());   // eof in a loop keeps the tag count
    loop_chunk(1, 3);                        // count continues from the old loop
    drain();

    // tag count saturation, then a tagless loop whose column wraps
    send_token(cifp_pkg::TK_DATA, random_ref());
    loop_chunk(cifp_pkg::MAX_TAGS_DEFAULT + 1, 2);
    send_token(cifp_pkg::TK_DATA, random_ref());
    loop_chunk(0, cifp_pkg::MAX_TAGS_DEFAULT + 2);
    drain();

    // random structured traffic with idling, drained now and then
    stop_at = sent_n + RANDOM_ITEMS;
    while (sent_n < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      random_chunk();
      if ($urandom_range(0, 29) == 0) drain();
    end

    // last stretch at full rate, no idling on either side
    idle_on = 1'b0;
    stop_at = sent_n + CALM_ITEMS;
    while (sent_n < stop_at) random_chunk();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d tokens and %0d checked events", sent_n, events_seen);
    $display("event codes seen (bit per code, begin_data lowest): %b", codes_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cifp_pkg.sv
rtl/cifp_step.sv
rtl/cif_token_structure_parser.sv
test/cifp_event_checker.sv
test/cif_token_structure_parser_tb.sv
